// ===== src/vla2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vla2d_pkg
// Shared widths, codes, constants and the arctangent table of the 2D vector
// length and azimuth block.
// ----------------------------------------------------------------------------
package vla2d_pkg;

   localparam int FIELD_WIDTH     = 32;
   localparam int LEN_WIDTH       = 33;
   localparam int RAD_WIDTH       = 31;
   localparam int DEG_WIDTH       = 25;
   localparam int TOL_WIDTH       = 16;
   localparam int BAM_WIDTH       = 32;
   localparam int GUARD_BITS      = 8;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ANGLE_MODE = 1'b0,
      CSR_VERT_TOL   = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_AZIMUTH  = 1'b0,
      MODE_CCW_EAST = 1'b1
   } angle_mode_type;

   // Inverse CORDIC gain, Q0.32.
   localparam logic [31:0] INV_GAIN_Q32     = 32'h9B74_EDA8;
   localparam logic [31:0] RAD_PER_TURN_Q28 = 32'd1686629713;
   localparam logic [31:0] DEG_PER_TURN_Q16 = 32'd23592960;
   localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

   localparam logic [BAM_WIDTH-1:0] BAM_ZERO          = 32'h0000_0000;
   localparam logic [BAM_WIDTH-1:0] BAM_QUARTER       = 32'h4000_0000;
   localparam logic [BAM_WIDTH-1:0] BAM_HALF          = 32'h8000_0000;
   localparam logic [BAM_WIDTH-1:0] BAM_THREE_QUARTER = 32'hC000_0000;

   typedef struct packed {
      logic null_vec;
      logic vertical;
      logic dy_neg;
   } flags_type;

   // atan(2^-i) in binary-angle units, one full turn being 2^32.
   function automatic logic [BAM_WIDTH-1:0] atan_turn(input int idx);
      logic [BAM_WIDTH-1:0] val;
      case (idx)
         0:  val = 32'h2000_0000;
         1:  val = 32'h12E4_051E;
         2:  val = 32'h09FB_385B;
         3:  val = 32'h0511_11D4;
         4:  val = 32'h028B_0D43;
         5:  val = 32'h0145_D7E1;
         6:  val = 32'h00A2_F61E;
         7:  val = 32'h0051_7C55;
         8:  val = 32'h0028_BE53;
         9:  val = 32'h0014_5F2F;
         10: val = 32'h000A_2F98;
         11: val = 32'h0005_17CC;
         12: val = 32'h0002_8BE6;
         13: val = 32'h0001_45F3;
         14: val = 32'h0000_A2FA;
         15: val = 32'h0000_517D;
         16: val = 32'h0000_28BE;
         17: val = 32'h0000_145F;
         18: val = 32'h0000_0A30;
         19: val = 32'h0000_0518;
         20: val = 32'h0000_028C;
         21: val = 32'h0000_0146;
         22: val = 32'h0000_00A3;
         23: val = 32'h0000_0051;
         24: val = 32'h0000_0029;
         25: val = 32'h0000_0014;
         26: val = 32'h0000_000A;
         27: val = 32'h0000_0005;
         28: val = 32'h0000_0003;
         29: val = 32'h0000_0001;
         30: val = 32'h0000_0001;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

// ===== src/vector_length_azimuth_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_length_azimuth_2d
// Length and direction of the vector between two fixed-point 2D points,
// computed by a fully pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
//  Channel   Ports                                    Handshake
//  request   req_x_start/x_end/y_start/y_end          start high, busy low
//  response  rsp_length/angle_rad/angle_deg/null_vec  rsp_valid, one cycle
//  config    csr_index, csr_wdata                     csr_wr_en, no wait
//
// One item enters every cycle; busy never rises. Each result passes
// through two front stages, one stage per CORDIC rotation and three
// stages for gain removal and angle conversion.
// Synchronous reset empties the pipeline and restores the registers.
// The receiver cannot stall, so nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
module vector_length_azimuth_2d
   import vla2d_pkg::*;
#(
   parameter int COORD_WIDTH   = 32,
   parameter int CORDIC_STAGES = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [FIELD_WIDTH-1:0]     req_x_start,
   input  logic [FIELD_WIDTH-1:0]     req_x_end,
   input  logic [FIELD_WIDTH-1:0]     req_y_start,
   input  logic [FIELD_WIDTH-1:0]     req_y_end,
   output logic                       rsp_valid,
   output logic [LEN_WIDTH-1:0]       rsp_length,
   output logic [RAD_WIDTH-1:0]       rsp_angle_rad,
   output logic [DEG_WIDTH-1:0]       rsp_angle_deg,
   output logic                       rsp_null_vector,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Guard bits, one bit of difference and headroom for the CORDIC gain.
   localparam int DATA_WIDTH = COORD_WIDTH + GUARD_BITS + 4;

   logic                 angle_mode_ff, angle_mode_in;
   logic [TOL_WIDTH-1:0] tolerance_ff, tolerance_in;

   always_comb begin
      angle_mode_in = angle_mode_ff;
      tolerance_in  = tolerance_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ANGLE_MODE: angle_mode_in = csr_wdata[0];
            CSR_VERT_TOL:   tolerance_in  = csr_wdata[TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_mode_ff <= MODE_AZIMUTH;
         tolerance_ff  <= '0;
      end else begin
         angle_mode_ff <= angle_mode_in;
         tolerance_ff  <= tolerance_in;
      end
   end

   assign busy = 1'b0;

   logic                         valid_pipe [0:CORDIC_STAGES];
   flags_type                    flags_pipe [0:CORDIC_STAGES];
   logic signed [DATA_WIDTH-1:0] x_pipe     [0:CORDIC_STAGES];
   logic signed [DATA_WIDTH-1:0] y_pipe     [0:CORDIC_STAGES];
   logic [BAM_WIDTH-1:0]         z_pipe     [0:CORDIC_STAGES];

   vla2d_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .x_start   (req_x_start),
      .x_end     (req_x_end),
      .y_start   (req_y_start),
      .y_end     (req_y_end),
      .tolerance (tolerance_ff),
      .out_valid (valid_pipe[0]),
      .out_flags (flags_pipe[0]),
      .out_x     (x_pipe[0]),
      .out_y     (y_pipe[0]),
      .out_z     (z_pipe[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      vla2d_cordic_stage #(
         .DATA_WIDTH (DATA_WIDTH),
         .STAGE      (i)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .prev_valid (valid_pipe[i]),
         .prev_flags (flags_pipe[i]),
         .prev_x     (x_pipe[i]),
         .prev_y     (y_pipe[i]),
         .prev_z     (z_pipe[i]),
         .next_valid (valid_pipe[i+1]),
         .next_flags (flags_pipe[i+1]),
         .next_x     (x_pipe[i+1]),
         .next_y     (y_pipe[i+1]),
         .next_z     (z_pipe[i+1])
      );
   end

   vla2d_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (valid_pipe[CORDIC_STAGES]),
      .in_flags        (flags_pipe[CORDIC_STAGES]),
      .in_x            (x_pipe[CORDIC_STAGES]),
      .in_z            (z_pipe[CORDIC_STAGES]),
      .angle_mode      (angle_mode_ff),
      .rsp_valid       (rsp_valid),
      .rsp_length      (rsp_length),
      .rsp_angle_rad   (rsp_angle_rad),
      .rsp_angle_deg   (rsp_angle_deg),
      .rsp_null_vector (rsp_null_vector)
   );

endmodule

// ===== src/vla2d_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vla2d_front
// Two stages: coordinate differences, then null and vertical detection and
// the half-turn prerotation into the right half plane.
// ----------------------------------------------------------------------------
module vla2d_front
   import vla2d_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int DATA_WIDTH  = COORD_WIDTH + 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [FIELD_WIDTH-1:0]       x_start,
   input  logic [FIELD_WIDTH-1:0]       x_end,
   input  logic [FIELD_WIDTH-1:0]       y_start,
   input  logic [FIELD_WIDTH-1:0]       y_end,
   input  logic [TOL_WIDTH-1:0]         tolerance,
   output logic                         out_valid,
   output flags_type                    out_flags,
   output logic signed [DATA_WIDTH-1:0] out_x,
   output logic signed [DATA_WIDTH-1:0] out_y,
   output logic [BAM_WIDTH-1:0]         out_z
);

   localparam int DIFF_WIDTH = COORD_WIDTH + 1;

   // Only the low COORD_WIDTH bits of a field form the coordinate.
   function automatic logic signed [DIFF_WIDTH-1:0] coord_ext(
      input logic [FIELD_WIDTH-1:0] raw);
      logic [COORD_WIDTH-1:0] c;
      c = COORD_WIDTH'(raw);
      return DIFF_WIDTH'(signed'(c));
   endfunction

   logic                         valid_a_ff;
   logic signed [DIFF_WIDTH-1:0] dx_ff, dx_in;
   logic signed [DIFF_WIDTH-1:0] dy_ff, dy_in;

   assign dx_in = coord_ext(x_end) - coord_ext(x_start);
   assign dy_in = coord_ext(y_end) - coord_ext(y_start);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

   logic                         dx_neg;
   logic signed [DATA_WIDTH-1:0] dx_wide, dy_wide;
   logic [DIFF_WIDTH-1:0]        adx;
   logic signed [DATA_WIDTH-1:0] x_in, y_in;
   logic [BAM_WIDTH-1:0]         z_in;
   flags_type                    flags_in;

   always_comb begin
      dx_neg  = dx_ff[DIFF_WIDTH-1];
      dx_wide = DATA_WIDTH'(dx_ff) <<< GUARD_BITS;
      dy_wide = DATA_WIDTH'(dy_ff) <<< GUARD_BITS;
      adx     = dx_neg ? $unsigned(-dx_ff) : $unsigned(dx_ff);
      // A vector pointing left is turned by half a turn first.
      x_in    = dx_neg ? -dx_wide : dx_wide;
      y_in    = dx_neg ? -dy_wide : dy_wide;
      z_in    = dx_neg ? BAM_HALF : BAM_ZERO;
      flags_in.null_vec = (dx_ff == '0) && (dy_ff == '0);
      flags_in.vertical = adx <= DIFF_WIDTH'(tolerance);
      flags_in.dy_neg   = dy_ff[DIFF_WIDTH-1];
   end

   logic                         valid_b_ff;
   flags_type                    flags_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, y_ff;
   logic [BAM_WIDTH-1:0]         z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      flags_ff <= flags_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
   end

   assign out_valid = valid_b_ff;
   assign out_flags = flags_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

// ===== src/vla2d_cordic_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vla2d_cordic_stage
// One registered vectoring CORDIC micro-rotation, driving y toward zero.
// ----------------------------------------------------------------------------
module vla2d_cordic_stage
   import vla2d_pkg::*;
#(
   parameter int DATA_WIDTH = 44,
   parameter int STAGE      = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         prev_valid,
   input  flags_type                    prev_flags,
   input  logic signed [DATA_WIDTH-1:0] prev_x,
   input  logic signed [DATA_WIDTH-1:0] prev_y,
   input  logic [BAM_WIDTH-1:0]         prev_z,
   output logic                         next_valid,
   output flags_type                    next_flags,
   output logic signed [DATA_WIDTH-1:0] next_x,
   output logic signed [DATA_WIDTH-1:0] next_y,
   output logic [BAM_WIDTH-1:0]         next_z
);

   localparam logic [BAM_WIDTH-1:0] ATAN_STEP = atan_turn(STAGE);

   logic signed [DATA_WIDTH-1:0] xs, ys;
   logic signed [DATA_WIDTH-1:0] x_in, y_in, x_ff, y_ff;
   logic [BAM_WIDTH-1:0]         z_in, z_ff;
   logic                         valid_ff;
   flags_type                    flags_ff;

   always_comb begin
      xs = prev_x >>> STAGE;
      ys = prev_y >>> STAGE;
      if (!prev_y[DATA_WIDTH-1]) begin
         x_in = prev_x + ys;
         y_in = prev_y - xs;
         z_in = prev_z + ATAN_STEP;
      end else begin
         x_in = prev_x - ys;
         y_in = prev_y + xs;
         z_in = prev_z - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
      end
      flags_ff <= prev_flags;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
   end

   assign next_valid = valid_ff;
   assign next_flags = flags_ff;
   assign next_x     = x_ff;
   assign next_y     = y_ff;
   assign next_z     = z_ff;

endmodule

// ===== src/vla2d_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vla2d_back
// Gain removal and rounding of the length, angle reference selection and
// conversion of the binary angle to radians and degrees. Three stages.
// ----------------------------------------------------------------------------
module vla2d_back
   import vla2d_pkg::*;
#(
   parameter int DATA_WIDTH = 44
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  flags_type                    in_flags,
   input  logic signed [DATA_WIDTH-1:0] in_x,
   input  logic [BAM_WIDTH-1:0]         in_z,
   input  logic                         angle_mode,
   output logic                         rsp_valid,
   output logic [LEN_WIDTH-1:0]         rsp_length,
   output logic [RAD_WIDTH-1:0]         rsp_angle_rad,
   output logic [DEG_WIDTH-1:0]         rsp_angle_deg,
   output logic                         rsp_null_vector
);

   // Stage 1: two 32x32 partial products of the length, angle selection.
   logic [63:0]          xp;
   logic [63:0]          prod_hi_in, prod_lo_in, prod_hi_ff, prod_lo_ff;
   logic [BAM_WIDTH-1:0] bam_in, bam_ff;
   logic                 valid1_ff;
   flags_type            flags1_ff;

   always_comb begin
      // x is never negative after the rotations.
      xp         = 64'($unsigned(in_x));
      prod_hi_in = 64'(xp[63:32]) * 64'(INV_GAIN_Q32);
      prod_lo_in = 64'(xp[31:0]) * 64'(INV_GAIN_Q32);
      if (in_flags.vertical) begin
         if (in_flags.dy_neg) begin
            bam_in = (angle_mode == MODE_CCW_EAST) ? BAM_THREE_QUARTER : BAM_HALF;
         end else begin
            bam_in = (angle_mode == MODE_CCW_EAST) ? BAM_QUARTER : BAM_ZERO;
         end
      end else begin
         bam_in = (angle_mode == MODE_CCW_EAST) ? in_z : BAM_QUARTER - in_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
      flags1_ff  <= in_flags;
      prod_hi_ff <= prod_hi_in;
      prod_lo_ff <= prod_lo_in;
      bam_ff     <= bam_in;
   end

   // Stage 2: length sum, rounding and saturation; angle products.
   logic [64:0]          len_sum, len_round;
   logic [LEN_WIDTH-1:0] len_in, len_ff;
   logic [63:0]          rad_prod_in, deg_prod_in, rad_prod_ff, deg_prod_ff;
   logic                 valid2_ff;
   flags_type            flags2_ff;

   always_comb begin
      len_sum     = 65'(prod_hi_ff) + 65'(prod_lo_ff[63:32]);
      len_round   = (len_sum + 65'(1 << (GUARD_BITS - 1))) >> GUARD_BITS;
      len_in      = (len_round > 65'(LEN_MAX)) ? LEN_MAX : len_round[LEN_WIDTH-1:0];
      rad_prod_in = 64'(bam_ff) * 64'(RAD_PER_TURN_Q28);
      deg_prod_in = 64'(bam_ff) * 64'(DEG_PER_TURN_Q16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      flags2_ff   <= flags1_ff;
      len_ff      <= len_in;
      rad_prod_ff <= rad_prod_in;
      deg_prod_ff <= deg_prod_in;
   end

   // Stage 3: result registers; a null vector overrides every field.
   logic                 out_valid_ff;
   logic [LEN_WIDTH-1:0] out_length_ff, out_length_in;
   logic [RAD_WIDTH-1:0] out_rad_ff, out_rad_in;
   logic [DEG_WIDTH-1:0] out_deg_ff, out_deg_in;
   logic                 out_null_ff;

   always_comb begin
      if (flags2_ff.null_vec) begin
         out_length_in = LEN_WIDTH'(1);
         out_rad_in    = '0;
         out_deg_in    = '0;
      end else begin
         out_length_in = len_ff;
         out_rad_in    = rad_prod_ff[32+RAD_WIDTH-1:32];
         out_deg_in    = deg_prod_ff[32+DEG_WIDTH-1:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid2_ff;
      end
      out_length_ff <= out_length_in;
      out_rad_ff    <= out_rad_in;
      out_deg_ff    <= out_deg_in;
      out_null_ff   <= flags2_ff.null_vec;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_length      = out_length_ff;
   assign rsp_angle_rad   = out_rad_ff;
   assign rsp_angle_deg   = out_deg_ff;
   assign rsp_null_vector = out_null_ff;

endmodule

// ===== src/vla2d_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vla2d_checker
// Port-level checks of the vector length and azimuth block, bound to the
// top level.
// ----------------------------------------------------------------------------
module vla2d_checker
   import vla2d_pkg::*;
#(
   parameter int CORDIC_STAGES = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic [FIELD_WIDTH-1:0] req_x_start,
   input logic [FIELD_WIDTH-1:0] req_x_end,
   input logic [FIELD_WIDTH-1:0] req_y_start,
   input logic [FIELD_WIDTH-1:0] req_y_end,
   input logic                   rsp_valid,
   input logic [LEN_WIDTH-1:0]   rsp_length,
   input logic [RAD_WIDTH-1:0]   rsp_angle_rad,
   input logic [DEG_WIDTH-1:0]   rsp_angle_deg,
   input logic                   rsp_null_vector
);

   localparam int LATENCY = CORDIC_STAGES + 5;

   // Every result belongs to an item that the block took earlier.
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching item");

   // An item with two identical points always comes back as a null vector.
   a_equal_points_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start && !busy && req_x_start == req_x_end
                          && req_y_start == req_y_end, LATENCY))
      |-> rsp_null_vector)
      else $error("coinciding points not flagged as null vector");

   a_null_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_null_vector)
      |-> (rsp_length == LEN_WIDTH'(1) && rsp_angle_rad == '0 && rsp_angle_deg == '0))
      else $error("null vector result with wrong fields");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_angle_rad) < RAD_PER_TURN_Q28
                     && 32'(rsp_angle_deg) < DEG_PER_TURN_Q16))
      else $error("angle at or beyond one full turn");

endmodule

bind vector_length_azimuth_2d vla2d_checker #(
   .CORDIC_STAGES (CORDIC_STAGES)
) u_vla2d_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_x_start     (req_x_start),
   .req_x_end       (req_x_end),
   .req_y_start     (req_y_start),
   .req_y_end       (req_y_end),
   .rsp_valid       (rsp_valid),
   .rsp_length      (rsp_length),
   .rsp_angle_rad   (rsp_angle_rad),
   .rsp_angle_deg   (rsp_angle_deg),
   .rsp_null_vector (rsp_null_vector)
);
